// ----- rtl/poly_derivative_eval_top_macros.svh -----
// Assertion macros used by the port-level verification checker.
`ifndef POLY_DERIVATIVE_EVAL_TOP_MACROS_SVH
`define POLY_DERIVATIVE_EVAL_TOP_MACROS_SVH

// Consequent must hold in the clock after the antecedent.
`define PDE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same clock as the antecedent.
`define PDE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pde_pkg.sv -----
// Types, constants and helper functions for the polynomial derivative evaluator.
package pde_pkg;

   localparam int OP_W       = 6;
   localparam int DIV_W      = 56;
   localparam int DIV_BITS   = 4;
   localparam int DIV_CYCLES = DIV_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
   localparam int FACT_W     = 48;

   localparam logic CSR_DERIV_ORDER = 1'b0;
   localparam logic CSR_EVAL_POINT  = 1'b1;

   localparam logic [63:0] ONE_Q16  = 64'h0000_0000_0001_0000;
   localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX64    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [FACT_W-1:0] FACT_MAX = '1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SKIP,
      ST_PROD_GO,
      ST_PROD_WAIT,
      ST_TERM_GO,
      ST_TERM_WAIT,
      ST_ACC,
      ST_POW_GO,
      ST_POW_WAIT,
      ST_FMUL_GO,
      ST_FMUL_WAIT,
      ST_FDIV_GO,
      ST_FDIV_WAIT,
      ST_FSET,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] x;
      logic [63:0] y;
      logic        neg;
      logic        rnd;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
      logic        sat;
   } mul_rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [OP_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [63:0] sext32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [63:0] abs64(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

endpackage

// ----- rtl/pde_mul.sv -----
// Shared sign-magnitude multiplier: 32x32 partial products, rounding and saturation.
module pde_mul (
   input  logic               clock,
   input  logic               reset,
   input  pde_pkg::mul_req_type req,
   output pde_pkg::mul_rsp_type rsp
);
   import pde_pkg::*;

   localparam logic [2:0] STEP_FIN = 3'd4;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [2:0]   step_ff, step_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  x_ff, x_in;
   logic [63:0]  y_ff, y_in;
   logic         neg_ff, neg_in;
   logic         rnd_ff, rnd_in;
   logic [63:0]  value_ff, value_in;
   logic         sat_ff, sat_in;

   logic [31:0]  a_sel;
   logic [31:0]  b_sel;
   logic [63:0]  pp;
   logic [127:0] pp_shift;
   logic [63:0]  mag;
   logic         hi_nz;
   logic [63:0]  lim;
   logic         over;
   logic [63:0]  clip;

   assign a_sel = step_ff[1] ? x_ff[63:32] : x_ff[31:0];
   assign b_sel = step_ff[0] ? y_ff[63:32] : y_ff[31:0];
   assign pp    = 64'(a_sel) * 64'(b_sel);

   always_comb begin
      case ({step_ff[1] & step_ff[0], step_ff[1] ^ step_ff[0]})
         2'd0:    pp_shift = {64'd0, pp};
         2'd1:    pp_shift = {32'd0, pp, 32'd0};
         2'd2:    pp_shift = {pp, 64'd0};
         default: pp_shift = '0;
      endcase
   end

   assign mag   = rnd_ff ? acc_ff[79:16] : acc_ff[63:0];
   assign hi_nz = rnd_ff ? (|acc_ff[127:80]) : (|acc_ff[127:64]);
   assign lim   = neg_ff ? SIGN64 : MAX64;
   assign over  = hi_nz || (mag > lim);
   assign clip  = over ? lim : mag;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      acc_in   = acc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      neg_in   = neg_ff;
      rnd_in   = rnd_ff;
      value_in = value_ff;
      sat_in   = sat_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         acc_in  = req.rnd ? 128'h8000 : 128'd0;
         x_in    = req.x;
         y_in    = req.y;
         neg_in  = req.neg;
         rnd_in  = req.rnd;
      end else if (busy_ff) begin
         if (step_ff == STEP_FIN) begin
            value_in = neg_ff ? (64'd0 - clip) : clip;
            sat_in   = over;
            done_in  = 1'b1;
            busy_in  = 1'b0;
         end else begin
            acc_in  = acc_ff + pp_shift;
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      acc_ff   <= acc_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      neg_ff   <= neg_in;
      rnd_ff   <= rnd_in;
      value_ff <= value_in;
      sat_ff   <= sat_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;
   assign rsp.sat   = sat_ff;

endmodule

// ----- rtl/pde_div.sv -----
// Restoring divider for the falling factorial, four quotient bits per clock.
module pde_div (
   input  logic               clock,
   input  logic               reset,
   input  pde_pkg::div_req_type req,
   output pde_pkg::div_rsp_type rsp
);
   import pde_pkg::*;

   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [OP_W-1:0]      rem_ff, rem_in;
   logic [OP_W-1:0]      den_ff, den_in;

   logic [DIV_W-1:0] num_step;
   logic [OP_W-1:0]  rem_step;
   logic [OP_W:0]    trial;

   always_comb begin
      num_step = num_ff;
      rem_step = rem_ff;
      trial    = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial    = {rem_step, num_step[DIV_W-1]};
         num_step = {num_step[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial       = trial - {1'b0, den_ff};
            num_step[0] = 1'b1;
         end
         rem_step = trial[OP_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         num_in = num_step;
         rem_in = rem_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff;

endmodule

// ----- rtl/poly_derivative_eval_top.sv -----
// Polynomial n-th derivative evaluator: sequencer, polynomial state and ports.
//
// Coefficients arrive lowest power first, one transaction each, and the block
// holds req_ready low while it works on one. Every multiply runs on one shared
// 32x32 multiplier in four partial products plus a rounding step, and the
// falling factorial update runs through a restoring divider that retires four
// bits a cycle over 56 bits. A coefficient at or above the derivative order
// takes four multiplies, one add and one divide; the last one stops after the
// add. A coefficient below the order takes one multiply and one divide, and one
// beyond MAX_TERMS is skipped. The last coefficient then passes a done state
// that loads the result register, which waits for rsp_ready while the next
// polynomial starts; if the previous result is still waiting there, the block
// stalls in that state until it is taken.
module poly_derivative_eval_top #(
   parameter int MAX_TERMS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_coeff,
   input  logic               req_last_coeff,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_value,
   output logic               rsp_overflow,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata
);
   import pde_pkg::*;

   localparam int IW = $clog2(MAX_TERMS + 1);
   localparam logic [IW-1:0] MAX_IDX = IW'(MAX_TERMS);

   state_type          state_ff, state_in;
   logic [31:0]        coeff_ff, coeff_in;
   logic               last_ff, last_in;
   logic [63:0]        sum_ff, sum_in;
   logic [63:0]        power_ff, power_in;
   logic [FACT_W-1:0]  fact_ff, fact_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic               sat_ff, sat_in;
   logic [3:0]         order_ff;
   logic [31:0]        point_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_value_ff, rsp_value_in;
   logic               rsp_overflow_ff, rsp_overflow_in;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [OP_W-1:0] idx_plus;
   logic [OP_W-1:0] order_ext;
   logic            below_order;
   logic [63:0]     add_sum;
   logic            add_ovf;
   logic [63:0]     coeff_ext;
   logic [63:0]     point_ext;

   assign idx_plus    = OP_W'(idx_ff) + 1'b1;
   assign order_ext   = OP_W'(order_ff);
   assign below_order = OP_W'(idx_ff) < order_ext;
   assign add_sum     = sum_ff + mul_rsp.value;
   assign add_ovf     = (sum_ff[63] == mul_rsp.value[63]) && (add_sum[63] != sum_ff[63]);
   assign coeff_ext   = sext32(coeff_ff);
   assign point_ext   = sext32(point_ff);

   pde_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   pde_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in        = state_ff;
      coeff_in        = coeff_ff;
      last_in         = last_ff;
      sum_in          = sum_ff;
      power_in        = power_ff;
      fact_in         = fact_ff;
      idx_in          = idx_ff;
      sat_in          = sat_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_value_in    = rsp_value_ff;
      rsp_overflow_in = rsp_overflow_ff;
      mul_req         = '0;
      div_req         = '0;
      req_ready       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               coeff_in = req_coeff;
               last_in  = req_last_coeff;
               if (idx_ff >= MAX_IDX) begin
                  state_in = ST_SKIP;
               end else if (below_order) begin
                  state_in = ST_FMUL_GO;
               end else begin
                  state_in = ST_PROD_GO;
               end
            end
         end
         ST_SKIP: begin
            state_in = last_ff ? ST_DONE : ST_IDLE;
         end
         ST_PROD_GO: begin
            mul_req.start = 1'b1;
            mul_req.x     = abs64(coeff_ext);
            mul_req.y     = abs64(power_ff);
            mul_req.neg   = coeff_ff[31] ^ power_ff[63];
            mul_req.rnd   = 1'b1;
            state_in      = ST_PROD_WAIT;
         end
         ST_PROD_WAIT: begin
            if (mul_rsp.done) begin
               sat_in   = sat_ff | mul_rsp.sat;
               state_in = ST_TERM_GO;
            end
         end
         ST_TERM_GO: begin
            mul_req.start = 1'b1;
            mul_req.x     = abs64(mul_rsp.value);
            mul_req.y     = 64'(fact_ff);
            mul_req.neg   = mul_rsp.value[63];
            mul_req.rnd   = 1'b0;
            state_in      = ST_TERM_WAIT;
         end
         ST_TERM_WAIT: begin
            if (mul_rsp.done) begin
               sat_in   = sat_ff | mul_rsp.sat;
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (add_ovf) begin
               sum_in = sum_ff[63] ? SIGN64 : MAX64;
               sat_in = 1'b1;
            end else begin
               sum_in = add_sum;
            end
            if (last_ff) begin
               idx_in   = IW'(idx_plus);
               state_in = ST_DONE;
            end else begin
               state_in = ST_POW_GO;
            end
         end
         ST_POW_GO: begin
            mul_req.start = 1'b1;
            mul_req.x     = abs64(power_ff);
            mul_req.y     = abs64(point_ext);
            mul_req.neg   = power_ff[63] ^ point_ff[31];
            mul_req.rnd   = 1'b1;
            state_in      = ST_POW_WAIT;
         end
         ST_POW_WAIT: begin
            if (mul_rsp.done) begin
               power_in = mul_rsp.value;
               sat_in   = sat_ff | mul_rsp.sat;
               state_in = ST_FMUL_GO;
            end
         end
         ST_FMUL_GO: begin
            mul_req.start = 1'b1;
            mul_req.x     = 64'(fact_ff);
            mul_req.y     = 64'(idx_plus);
            mul_req.neg   = 1'b0;
            mul_req.rnd   = 1'b0;
            state_in      = ST_FMUL_WAIT;
         end
         ST_FMUL_WAIT: begin
            if (mul_rsp.done) begin
               state_in = ST_FDIV_GO;
            end
         end
         ST_FDIV_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_rsp.value[DIV_W-1:0];
            div_req.divisor  = below_order ? OP_W'(1) : (idx_plus - order_ext);
            state_in         = ST_FDIV_WAIT;
         end
         ST_FDIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_FSET;
            end
         end
         ST_FSET: begin
            if (|div_rsp.quotient[DIV_W-1:FACT_W]) begin
               fact_in = FACT_MAX;
               sat_in  = 1'b1;
            end else begin
               fact_in = div_rsp.quotient[FACT_W-1:0];
            end
            idx_in   = IW'(idx_plus);
            state_in = last_ff ? ST_DONE : ST_IDLE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_value_in    = sum_ff;
               rsp_overflow_in = sat_ff;
               sum_in          = '0;
               power_in        = ONE_Q16;
               fact_in         = FACT_W'(1);
               idx_in          = '0;
               sat_in          = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         power_ff     <= ONE_Q16;
         fact_ff      <= FACT_W'(1);
         idx_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         power_ff     <= power_in;
         fact_ff      <= fact_in;
         idx_ff       <= idx_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      coeff_ff        <= coeff_in;
      last_ff         <= last_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= '0;
         point_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DERIV_ORDER: order_ff <= csr_wdata[3:0];
            CSR_EVAL_POINT:  point_ff <= csr_wdata;
            default:         order_ff <= order_ff;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

// ----- rtl/pde_port_check.sv -----
// Port-level assertion checker for the derivative evaluator, with its bind.
`include "poly_derivative_eval_top_macros.svh"

module pde_port_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_value,
   input logic        rsp_overflow
);

   `PDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_overflow), "stalled response changed")
   `PDE_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, !rsp_valid && req_ready, "bad state after reset")
   `PDE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready && !$rose(rsp_valid), "accepted transaction did not hold the block busy")
   `PDE_ASSERT_NOW(a_ready_on_result, clock, reset, $rose(rsp_valid), req_ready, "result issued while block still busy")

endmodule

bind poly_derivative_eval_top pde_port_check u_pde_port_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_value    (rsp_value),
   .rsp_overflow (rsp_overflow)
);
